/* hw/rtl/asrc_pkg.sv */
// Shared types and constants of the adaptive sampling rate controller.
`timescale 1ns / 1ps

package asrc_pkg;

   // Field widths
   localparam int unsigned RATE_W  = 20;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned IVAL_W  = 32;
   localparam int unsigned TIME_W  = 48;
   localparam int unsigned RANGE_W = 15;

   // Datapath widths: the widest product is rate * time * range
   localparam int unsigned DIV_W   = RATE_W + TIME_W + RANGE_W + 1;
   localparam int unsigned DEN_W   = COUNT_W + RATE_W;
   localparam int unsigned CHUNK_W = 24;
   localparam int unsigned PROD_W  = 2 * CHUNK_W;
   localparam int unsigned OPA_W   = 3 * CHUNK_W;
   localparam int unsigned SHIFT_W = 7;

   // Microseconds per second
   localparam logic [RATE_W-1:0] USEC_PER_SEC = 20'd1000000;

   // Significant dividend bits of each division pass
   localparam logic [SHIFT_W-1:0] DIV_BITS_FIRST = 7'd84;
   localparam logic [SHIFT_W-1:0] DIV_BITS_EVER  = 7'd66;
   localparam logic [SHIFT_W-1:0] DIV_BITS_BLEND = 7'd56;

   // Datapath operations
   typedef enum logic [2:0] {
      DP_HOLD,
      DP_CLEAR,
      DP_MAC,
      DP_PRESHIFT,
      DP_DIV
   } dp_op_type;

   // One command to the shared multiply/divide unit
   typedef struct packed {
      dp_op_type          op;
      logic [1:0]         chunk;
      logic [CHUNK_W-1:0] mul_a;
      logic [CHUNK_W-1:0] mul_b;
      logic [SHIFT_W-1:0] shift_amt;
      logic [DEN_W-1:0]   divisor;
   } dp_cmd_type;

endpackage

/* hw/rtl/asrc_muldiv.sv */
// Shared multiply-accumulate and restoring divide unit of the controller.
`timescale 1ns / 1ps

module asrc_muldiv
   import asrc_pkg::*;
(
   input  logic             clock,
   input  dp_cmd_type       cmd,
   output logic [DIV_W-1:0] acc
);

   logic [DIV_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0] rem_ff, rem_in;

   logic [PROD_W-1:0] prod;
   logic [DIV_W-1:0]  prod_ext;
   logic [DIV_W-1:0]  addend;
   logic [DEN_W:0]    rem_sh;
   logic [DEN_W:0]    rem_diff;
   logic              rem_ge;

   // One 24x24 multiplier, product placed at the chunk position
   assign prod     = PROD_W'(cmd.mul_a) * PROD_W'(cmd.mul_b);
   assign prod_ext = DIV_W'(prod);

   always_comb begin
      unique case (cmd.chunk)
         2'd0:    addend = prod_ext;
         2'd1:    addend = prod_ext << CHUNK_W;
         2'd2:    addend = prod_ext << (2 * CHUNK_W);
         default: addend = '0;
      endcase
   end

   // One restoring divide step: next dividend bit into the remainder
   assign rem_sh   = {rem_ff, acc_ff[DIV_W-1]};
   assign rem_diff = rem_sh - {1'b0, cmd.divisor};
   assign rem_ge   = (rem_sh >= {1'b0, cmd.divisor});

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      unique case (cmd.op)
         DP_HOLD: begin
         end
         DP_CLEAR: begin
            acc_in = '0;
            rem_in = '0;
         end
         DP_MAC: begin
            acc_in = acc_ff + addend;
         end
         DP_PRESHIFT: begin
            acc_in = acc_ff << cmd.shift_amt;
            rem_in = '0;
         end
         DP_DIV: begin
            acc_in = {acc_ff[DIV_W-2:0], rem_ge};
            rem_in = rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign acc = acc_ff;

endmodule

/* hw/rtl/adaptive_sampling_rate_controller.sv */
// Top level of the adaptive sampling rate controller: sequencer and state.
`timescale 1ns / 1ps

// Keeps a sampling range in [1, SAMPLING_BASE] so that sampled events arrive
// at csr_expected_rate per second. A sample request (kind 0) and a grab round
// with no new samples go straight from idle to the finish state. A grab round
// with new samples runs on one shared 24x24 multiply-accumulate and
// one-bit-per-cycle divider: the first grab takes 84 divide steps, later
// rounds of at least one second 66, and later rounds shorter than one second
// add a second pass of 56 divide steps by 1e6 for the blend. The block takes
// one request at a time; a finished response sits in an output register while
// the next request is accepted. The user must write the expected rate
// register only while no request is in flight; the block does not enforce it.

module adaptive_sampling_rate_controller
   import asrc_pkg::*;
#(
   parameter int unsigned SAMPLING_BASE = 16384
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [COUNT_W-1:0]        req_total_count,
   input  logic signed [IVAL_W-1:0]  req_round_interval_us,
   input  logic [TIME_W-1:0]         req_now_us,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RANGE_W-1:0]        rsp_range,
   output logic                      rsp_wakeup,
   // configuration
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [RATE_W-1:0]         csr_expected_rate
);

   localparam logic [RANGE_W-1:0] BASE_R = RANGE_W'(SAMPLING_BASE);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_SETUP  = 11'b000_0000_0010,
      ST_MUL1   = 11'b000_0000_0100,
      ST_LOADA  = 11'b000_0000_1000,
      ST_MUL2   = 11'b000_0001_0000,
      ST_PRESH  = 11'b000_0010_0000,
      ST_DIV    = 11'b000_0100_0000,
      ST_LOADB  = 11'b000_1000_0000,
      ST_MUL3   = 11'b001_0000_0000,
      ST_ADDOLD = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } fsm_state_type;

   fsm_state_type state_ff, state_in;

   logic [RATE_W-1:0]  expected_ff, expected_in;
   logic [RANGE_W-1:0] range_ff, range_in;
   logic [COUNT_W-1:0] last_count_ff, last_count_in;
   logic               ever_ff, ever_in;
   logic [TIME_W-1:0]  stamp_ff, stamp_in;
   logic [COUNT_W-1:0] pre_cnt_ff, pre_cnt_in;

   logic [COUNT_W-1:0] round_ff, round_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [TIME_W-1:0]  interval_ff, interval_in;
   logic [OPA_W-1:0]   opa_ff, opa_in;
   logic [1:0]         chunk_ff, chunk_in;
   logic [SHIFT_W-1:0] cnt_ff, cnt_in;
   logic               blend_ff, blend_in;
   logic               upd_ff, upd_in;
   logic               wake_ff, wake_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RANGE_W-1:0] rsp_range_ff, rsp_range_in;
   logic               rsp_wakeup_ff, rsp_wakeup_in;

   dp_cmd_type         cmd;
   logic [DIV_W-1:0]   acc;

   logic               req_accept;
   logic               slot_free;
   logic [COUNT_W-1:0] round_cur;
   logic [TIME_W-1:0]  ival_pos;
   logic [TIME_W-1:0]  ival_sel;
   logic [CHUNK_W-1:0] opa_chunk;
   logic               short_round;
   logic [RANGE_W-1:0] clamped;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;
   assign csr_ready  = 1'b1;
   assign slot_free  = ~rsp_valid_ff | rsp_ready;

   // Interval of a grab round: negative is zero, first grab after samples uses the stamp
   assign round_cur = req_total_count - last_count_ff;
   assign ival_pos  = req_round_interval_us[IVAL_W-1] ? '0 :
                      TIME_W'(req_round_interval_us[IVAL_W-2:0]);
   always_comb begin
      if (~ever_ff && (pre_cnt_ff != '0)) begin
         ival_sel = (req_now_us >= stamp_ff) ? (req_now_us - stamp_ff) : '0;
      end else begin
         ival_sel = ival_pos;
      end
   end

   // Operand chunk for the multiply-accumulate
   always_comb begin
      unique case (chunk_ff)
         2'd0:    opa_chunk = opa_ff[CHUNK_W-1:0];
         2'd1:    opa_chunk = opa_ff[2*CHUNK_W-1:CHUNK_W];
         2'd2:    opa_chunk = opa_ff[3*CHUNK_W-1:2*CHUNK_W];
         default: opa_chunk = '0;
      endcase
   end

   assign short_round = (interval_ff < TIME_W'(USEC_PER_SEC));

   // Clamp the final quotient to [1, SAMPLING_BASE]
   always_comb begin
      priority if (acc == '0) begin
         clamped = RANGE_W'(1);
      end else if (acc > DIV_W'(BASE_R)) begin
         clamped = BASE_R;
      end else begin
         clamped = acc[RANGE_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      expected_in   = expected_ff;
      range_in      = range_ff;
      last_count_in = last_count_ff;
      ever_in       = ever_ff;
      stamp_in      = stamp_ff;
      pre_cnt_in    = pre_cnt_ff;
      round_in      = round_ff;
      den_in        = den_ff;
      interval_in   = interval_ff;
      opa_in        = opa_ff;
      chunk_in      = chunk_ff;
      cnt_in        = cnt_ff;
      blend_in      = blend_ff;
      upd_in        = upd_ff;
      wake_in       = wake_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_range_in  = rsp_range_ff;
      rsp_wakeup_in = rsp_wakeup_ff;

      cmd           = '0;
      cmd.op        = DP_HOLD;

      if (csr_valid && csr_ready) begin
         expected_in = csr_expected_rate;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               upd_in   = 1'b0;
               wake_in  = 1'b0;
               blend_in = 1'b0;
               state_in = ST_FINISH;
               if (~req_kind) begin
                  // sample request: count before the first grab
                  if (~ever_ff) begin
                     if (pre_cnt_ff != '1) begin
                        pre_cnt_in = pre_cnt_ff + COUNT_W'(1);
                     end
                     if (pre_cnt_ff == '0) begin
                        stamp_in = req_now_us;
                     end else if (pre_cnt_ff >= COUNT_W'(expected_ff)) begin
                        wake_in = 1'b1;
                     end
                  end
               end else if (round_cur != '0) begin
                  // grab round with new samples
                  last_count_in = req_total_count;
                  round_in      = round_cur;
                  interval_in   = ival_sel;
                  opa_in        = OPA_W'(ival_sel);
                  upd_in        = 1'b1;
                  state_in      = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            den_in   = DEN_W'(round_ff) * DEN_W'(USEC_PER_SEC);
            cmd.op   = DP_CLEAR;
            chunk_in = 2'd0;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            // rate * interval
            cmd.op    = DP_MAC;
            cmd.chunk = chunk_ff;
            cmd.mul_a = opa_chunk;
            cmd.mul_b = CHUNK_W'(expected_ff);
            chunk_in  = chunk_ff + 2'd1;
            if (chunk_ff == 2'd1) begin
               state_in = ST_LOADA;
            end
         end
         ST_LOADA: begin
            opa_in   = acc[OPA_W-1:0];
            cmd.op   = DP_CLEAR;
            chunk_in = 2'd0;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // times the old range, or the base on the first grab
            cmd.op    = DP_MAC;
            cmd.chunk = chunk_ff;
            cmd.mul_a = opa_chunk;
            cmd.mul_b = ever_ff ? CHUNK_W'(range_ff) : CHUNK_W'(BASE_R);
            chunk_in  = chunk_ff + 2'd1;
            if (chunk_ff == 2'd2) begin
               state_in = ST_PRESH;
            end
         end
         ST_PRESH: begin
            // align the dividend so only its significant bits are stepped
            cmd.op = DP_PRESHIFT;
            priority if (blend_ff) begin
               cnt_in = DIV_BITS_BLEND;
            end else if (ever_ff) begin
               cnt_in = DIV_BITS_EVER;
            end else begin
               cnt_in = DIV_BITS_FIRST;
            end
            cmd.shift_amt = SHIFT_W'(DIV_W) - cnt_in;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.op      = DP_DIV;
            cmd.divisor = blend_ff ? DEN_W'(USEC_PER_SEC) : den_ff;
            cnt_in      = cnt_ff - SHIFT_W'(1);
            if (cnt_ff == SHIFT_W'(1)) begin
               if (~blend_ff && ever_ff && short_round) begin
                  state_in = ST_LOADB;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LOADB: begin
            // short round: blend old and new ranges
            opa_in   = acc[OPA_W-1:0];
            blend_in = 1'b1;
            cmd.op   = DP_CLEAR;
            chunk_in = 2'd0;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.op    = DP_MAC;
            cmd.chunk = chunk_ff;
            cmd.mul_a = opa_chunk;
            cmd.mul_b = interval_ff[CHUNK_W-1:0];
            chunk_in  = chunk_ff + 2'd1;
            if (chunk_ff == 2'd2) begin
               state_in = ST_ADDOLD;
            end
         end
         ST_ADDOLD: begin
            cmd.op    = DP_MAC;
            cmd.chunk = 2'd0;
            cmd.mul_a = CHUNK_W'(range_ff);
            cmd.mul_b = CHUNK_W'(USEC_PER_SEC - interval_ff[RATE_W-1:0]);
            state_in  = ST_PRESH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_wakeup_in = wake_ff;
               if (upd_ff) begin
                  range_in     = clamped;
                  ever_in      = 1'b1;
                  rsp_range_in = clamped;
               end else begin
                  rsp_range_in = range_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expected_ff   <= RATE_W'(1000);
         range_ff      <= BASE_R;
         last_count_ff <= '0;
         ever_ff       <= 1'b0;
         stamp_ff      <= '0;
         pre_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         range_ff      <= range_in;
         last_count_ff <= last_count_in;
         ever_ff       <= ever_in;
         stamp_ff      <= stamp_in;
         pre_cnt_ff    <= pre_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working registers and response payload
   always_ff @(posedge clock) begin
      round_ff      <= round_in;
      den_ff        <= den_in;
      interval_ff   <= interval_in;
      opa_ff        <= opa_in;
      chunk_ff      <= chunk_in;
      cnt_ff        <= cnt_in;
      blend_ff      <= blend_in;
      upd_ff        <= upd_in;
      wake_ff       <= wake_in;
      rsp_range_ff  <= rsp_range_in;
      rsp_wakeup_ff <= rsp_wakeup_in;
   end

   asrc_muldiv u_muldiv (
      .clock (clock),
      .cmd   (cmd),
      .acc   (acc)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_range  = rsp_range_ff;
   assign rsp_wakeup = rsp_wakeup_ff;

endmodule

/* bench/adaptive_sampling_rate_controller_test.sv */
// Self-checking bench for the adaptive sampling rate controller.
`timescale 1ns / 1ps

module adaptive_sampling_rate_controller_test
   import asrc_pkg::*;
;

   localparam int unsigned SAMPLING_BASE  = 16384;
   localparam int unsigned RANDOM_ITEMS   = 1225;
   localparam int unsigned PHASES         = 7;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned SETTLE_CYCLES  = 200;
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   // request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_GRAB   = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [COUNT_W-1:0] total_count;
      logic [IVAL_W-1:0]  round_interval_us;
      logic [TIME_W-1:0]  now_us;
   } request_type;

   // Mirrors the controller state and keeps the responses still owed
   class range_scoreboard;
      typedef struct packed {
         logic [RANGE_W-1:0] range_val;
         logic               wakeup;
      } range_result_type;

      logic [RATE_W-1:0]  rate;
      logic [RANGE_W-1:0] range_q;
      logic [COUNT_W-1:0] last_count;
      logic [COUNT_W-1:0] samples_seen;
      logic [TIME_W-1:0]  first_stamp;
      bit                 grabbed;
      range_result_type   expected_ranges[$];
      int unsigned        errors;

      function new();
         rate = 20'd1000;
         range_q = RANGE_W'(SAMPLING_BASE);
         last_count = '0;
         samples_seen = '0;
         first_stamp = '0;
         grabbed = 1'b0;
         errors = 0;
      endfunction

      function void set_rate(logic [RATE_W-1:0] value);
         rate = value;
      endfunction

      function int unsigned pending();
         return expected_ranges.size();
      endfunction

      function void complain(string what);
         errors++;
         $display("%0t: %s", $time, what);
      endfunction

      // New sampling range after a grab round, full-width arithmetic
      function void update_range(logic [COUNT_W-1:0] total, logic [IVAL_W-1:0] ival,
                                 logic [TIME_W-1:0] now);
         logic [COUNT_W-1:0] round;
         logic [127:0]       span;
         logic [127:0]       den;
         logic [127:0]       old;
         logic [127:0]       quo;
         round = total - last_count;
         if (round == '0) return;
         last_count = total;
         span = ival[IVAL_W-1] ? 128'd0 : 128'(ival);
         den = 128'(USEC_PER_SEC) * 128'(round);
         old = 128'(range_q);
         if (!grabbed) begin
            // first round measures from the first sample stamp when there is one
            if (samples_seen != '0) begin
               span = (now >= first_stamp) ? 128'(now - first_stamp) : 128'd0;
            end
            quo = 128'(rate) * span * 128'(SAMPLING_BASE) / den;
         end else begin
            quo = 128'(rate) * span * old / den;
            // short rounds blend old and new ranges
            if (span < 128'(USEC_PER_SEC)) begin
               quo = (quo * span + old * (128'(USEC_PER_SEC) - span)) / 128'(USEC_PER_SEC);
            end
         end
         if (quo == 128'd0) begin
            range_q = RANGE_W'(1);
         end else if (quo > 128'(SAMPLING_BASE)) begin
            range_q = RANGE_W'(SAMPLING_BASE);
         end else begin
            range_q = quo[RANGE_W-1:0];
         end
         grabbed = 1'b1;
      endfunction

      // Accepted request: advance the state and queue the response it owes
      function void note_request(logic kind, logic [COUNT_W-1:0] total,
                                 logic [IVAL_W-1:0] ival, logic [TIME_W-1:0] now);
         logic [COUNT_W-1:0] before_count;
         logic               wake;
         range_result_type   entry;
         wake = 1'b0;
         if (kind == KIND_SAMPLE) begin
            if (!grabbed) begin
               before_count = samples_seen;
               if (samples_seen != '1) samples_seen++;
               if (before_count == '0) begin
                  first_stamp = now;
               end else if (before_count >= COUNT_W'(rate)) begin
                  wake = 1'b1;
               end
            end
         end else begin
            update_range(total, ival, now);
         end
         entry.range_val = range_q;
         entry.wakeup = wake;
         expected_ranges.insert(expected_ranges.size(), entry);
      endfunction

      function void check_response(logic [RANGE_W-1:0] got_range, logic got_wake);
         range_result_type want;
         if (expected_ranges.size() == 0) begin
            complain($sformatf("unexpected response: range %0d wakeup %0d",
                               got_range, got_wake));
            return;
         end
         want = expected_ranges.pop_front();
         if (got_range !== want.range_val) begin
            complain($sformatf("range expected %0d, got %0d",
                               want.range_val, got_range));
         end
         if (got_wake !== want.wakeup) begin
            complain($sformatf("wakeup expected %0d, got %0d", want.wakeup, got_wake));
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_kind = KIND_SAMPLE;
   logic [COUNT_W-1:0]       req_total_count = '0;
   logic signed [IVAL_W-1:0] req_round_interval_us = '0;
   logic [TIME_W-1:0]        req_now_us = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [RANGE_W-1:0]       rsp_range;
   logic                     rsp_wakeup;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [RATE_W-1:0]        csr_expected_rate = '0;

   range_scoreboard sb = new();

   // stimulus-side view of the running count, time and rate
   logic [COUNT_W-1:0] count_cursor = '0;
   logic [TIME_W-1:0]  clock_us = '0;
   logic [RATE_W-1:0]  cur_rate = 20'd1000;
   int unsigned        burst_left = 0;
   bit                 hold_armed = 1'b0;
   int unsigned        idle_cycles = 0;

   adaptive_sampling_rate_controller #(
      .SAMPLING_BASE(SAMPLING_BASE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_total_count(req_total_count),
      .req_round_interval_us(req_round_interval_us),
      .req_now_us(req_now_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_range(rsp_range),
      .rsp_wakeup(rsp_wakeup),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_expected_rate(csr_expected_rate)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: every handshake seen at the edge, pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_rate(csr_expected_rate);
         if (req_valid && req_ready) begin
            sb.note_request(req_kind, req_total_count, req_round_interval_us, req_now_us);
         end
         if (rsp_valid && rsp_ready) sb.check_response(rsp_range, rsp_wakeup);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Response side: stall patterns, plus one long hold-off to back up the input
   initial begin
      int unsigned     stretch;
      logic [15:0]     ready_pattern;
      bit              hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stretch = $urandom_range(20, 300);
         case ($urandom_range(0, 3))
            0: ready_pattern = 16'hFFFF;
            1: ready_pattern = 16'($urandom) | 16'h0001;
            2: ready_pattern = 16'h0001 << $urandom_range(0, 15);
            default: ready_pattern = 16'($urandom) | 16'h8421;
         endcase
         for (int i = 0; i < stretch; i++) begin
            rsp_ready <= ready_pattern[i % 16];
            @(posedge clock);
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand48();
      return TIME_W'({$urandom, $urandom});
   endfunction

   // Offer one request, hold it until taken, then maybe pause the burst
   task automatic send_request(request_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_kind <= item.kind;
      req_total_count <= item.total_count;
      req_round_interval_us <= item.round_interval_us;
      req_now_us <= item.now_us;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 30);
         case ($urandom_range(0, 7))
            0: gap = $urandom_range(60, 160);
            1, 2, 3: gap = 0;
            default: gap = $urandom_range(1, 12);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_grab(logic [COUNT_W-1:0] total, logic [IVAL_W-1:0] ival,
                            logic [TIME_W-1:0] now);
      count_cursor = total;
      send_request('{KIND_GRAB, total, ival, now});
   endtask

   task automatic send_sample(logic [TIME_W-1:0] now);
      send_request('{KIND_SAMPLE, COUNT_W'($urandom), IVAL_W'($urandom), now});
   endtask

   // Stop offering and wait until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_rate(logic [RATE_W-1:0] value);
      cur_rate = value;
      csr_valid <= 1'b1;
      csr_expected_rate <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly plausible grab rounds sized to the rate, some samples and noise
   function automatic request_type random_request();
      request_type     item;
      int unsigned     roll;
      longint unsigned quota;
      roll = $urandom_range(0, 99);
      item.kind = KIND_GRAB;
      item.total_count = $urandom;
      item.round_interval_us = $urandom;
      item.now_us = rand48();
      if (roll < 15) begin
         item.kind = KIND_SAMPLE;
      end else if (roll < 82) begin
         case ($urandom_range(0, 9))
            0, 1: item.round_interval_us = $urandom_range(1000000, 5000000);
            2: item.round_interval_us = $urandom_range(0, 999999);
            3: item.round_interval_us = '0;
            default: item.round_interval_us = $urandom_range(50000, 150000);
         endcase
         quota = 64'(cur_rate) * 64'(item.round_interval_us) / 64'd1000000;
         if ($urandom_range(0, 3) == 0) begin
            quota = $urandom_range(1, 20);
         end else begin
            quota = quota * $urandom_range(25, 400) / 100;
         end
         if (quota == 0) quota = 1;
         count_cursor = count_cursor + COUNT_W'(quota);
         clock_us = clock_us + TIME_W'(item.round_interval_us);
         item.total_count = count_cursor;
         item.now_us = clock_us;
      end else if (roll < 92) begin
         // empty round
         item.total_count = count_cursor;
      end else begin
         count_cursor = item.total_count;
      end
      return item;
   endfunction

   // Main sequence
   initial begin
      int unsigned       opening;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] grab_now;
      logic [COUNT_W-1:0] first_total;
      logic [RATE_W-1:0] phase_rates[PHASES];

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before the first grab: either no samples at all, time going back, or a
      // normal stamp-to-grab span (sometimes huge, for the widest product)
      opening = $urandom_range(0, 2);
      first_total = $urandom_range(1, 40);
      if (opening == 0) begin
         send_grab('0, $urandom, rand48());
         if ($urandom_range(0, 1) == 0) begin
            send_grab(first_total, 32'h8000_0000 | $urandom, rand48());
         end else begin
            send_grab(first_total, $urandom_range(1, 3000000), rand48());
         end
      end else begin
         stamp = (rand48() >> 1) | 48'd1;
         send_sample(stamp);
         send_sample(stamp + 48'd10);
         send_sample('0);
         drain();
         write_rate(RATE_W'($urandom_range(0, 4)));
         send_sample('1);
         repeat (5) send_sample(rand48());
         send_grab('0, $urandom, rand48());
         if (opening == 1) begin
            grab_now = stamp >> 1;
         end else if ($urandom_range(0, 1) == 0) begin
            grab_now = stamp + TIME_W'(rand48() >> 1);
         end else begin
            grab_now = stamp + TIME_W'($urandom_range(1, 2000000));
         end
         send_grab(first_total, $urandom, grab_now);
      end
      clock_us = rand48() >> 2;

      // After the first grab: interval edges, count wrap, clamps
      drain();
      write_rate(USEC_PER_SEC);
      send_sample(rand48());
      send_grab(count_cursor, 32'd100000, clock_us);
      send_grab(count_cursor + 1, 32'h8000_0000, clock_us);
      send_grab(count_cursor + 1, 32'hFFFF_FFFF, clock_us);
      send_grab(count_cursor + 1, '0, clock_us);
      send_grab(count_cursor + 1, 32'd999999, clock_us);
      send_grab(count_cursor + 1, 32'd1000000, clock_us);
      send_grab(count_cursor + 1, 32'h7FFF_FFFF, clock_us);
      send_grab(count_cursor - 1, 32'd100000, clock_us);
      send_grab(32'hFFFF_FFFF, 32'd1000000, clock_us);
      send_grab('0, 32'd2000000, clock_us);
      drain();
      write_rate('0);
      send_grab(count_cursor + 1, 32'd1000000, clock_us);

      // Random phases, one rate each, extremes included
      phase_rates = '{20'd1, 20'hFFFFF, 20'd0, RATE_W'($urandom_range(1, 1000000)),
                      20'd1000, USEC_PER_SEC, RATE_W'($urandom_range(2, 5000))};
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_rate(phase_rates[p]);
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (p == 0 && n == 40) hold_armed = 1'b1;
            send_request(random_request());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/asrc_pkg.sv
hw/rtl/asrc_muldiv.sv
hw/rtl/adaptive_sampling_rate_controller.sv
bench/adaptive_sampling_rate_controller_test.sv
